### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk and switched off while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### sv/bsws_pkg.sv
`default_nettype none

package bsws_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CFG_W         = 5;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int WORD_W        = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SWAP = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        RS_TOP,
        RS_SECOND
    } t_rsel;

    typedef enum logic [1:0] {
        WS_PUSH,
        WS_TOP,
        WS_SECOND
    } t_wsel;

    typedef struct packed {
        logic    rd_en;
        t_rsel   rsel;
        logic    wr_en;
        t_wsel   wsel;
        logic    hold_load;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_load;
        logic    res_popped;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic two;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/bsws_ctrl.sv
`default_nettype none

module bsws_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_op,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire bsws_pkg::t_dp_stat i_stat,
    output bsws_pkg::t_dp_cmd       o_cmd
);
    import bsws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SW1,
        S_SW2,
        S_SW3
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;
    logic    accept;

    always_comb begin
        cmd            = '0;
        cmd.rsel       = RS_TOP;
        cmd.wsel       = WS_PUSH;
        cmd.res_status = ST_OK;
        n_state        = r_state;
        o_in_ready     = 1'b0;
        accept         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                accept     = o_in_ready && i_in_valid;
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_PUSH: begin
                            cmd.res_load = 1'b1;
                            if (i_stat.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.wsel    = WS_PUSH;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (i_stat.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.rd_en   = 1'b1;
                                cmd.rsel    = RS_TOP;
                                cmd.cnt_dec = 1'b1;
                                n_state     = S_POP;
                            end
                        end
                        OP_SWAP: begin
                            if (i_stat.two) begin
                                cmd.rd_en = 1'b1;
                                cmd.rsel  = RS_TOP;
                                n_state   = S_SW1;
                            end else begin
                                cmd.res_load = 1'b1;
                            end
                        end
                        OP_NOP: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                cmd.res_load   = 1'b1;
                cmd.res_popped = 1'b1;
                n_state        = S_IDLE;
            end
            S_SW1: begin
                cmd.rd_en     = 1'b1;
                cmd.rsel      = RS_SECOND;
                cmd.hold_load = 1'b1;
                n_state       = S_SW2;
            end
            S_SW2: begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = WS_TOP;
                n_state   = S_SW3;
            end
            S_SW3: begin
                cmd.wr_en    = 1'b1;
                cmd.wsel     = WS_SECOND;
                cmd.res_load = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### sv/bsws_dpath.sv
`default_nettype none

module bsws_dpath #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bsws_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic signed [bsws_pkg::WORD_W-1:0] i_push_value,
    input  wire bsws_pkg::t_dp_cmd               i_cmd,
    output bsws_pkg::t_dp_stat                   o_stat,
    output logic [bsws_pkg::STATUS_W-1:0]        o_status,
    output logic signed [bsws_pkg::WORD_W-1:0]   o_popped_value,
    output logic [bsws_pkg::COUNT_OUT_W-1:0]     o_entry_count,
    output logic                                 o_is_full,
    output logic                                 o_is_empty
);
    import bsws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]  r_cap;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_hold;

    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [EW-1:0]     cap_e;
    logic [EW-1:0]     eff_cap;
    logic [EW-1:0]     cnt_e;
    logic [EW-1:0]     n_cnt_e;

    logic [STATUS_W-1:0]    r_status;
    logic [WORD_W-1:0]      r_popped;
    logic [COUNT_OUT_W-1:0] r_entry_count;
    logic                   r_is_full;
    logic                   r_is_empty;

    always_comb begin
        count_m1 = r_count - CW'(1);
        count_m2 = r_count - CW'(2);
        cap_e    = EW'(r_cap);
        eff_cap  = (cap_e > DEPTH_E) ? DEPTH_E : cap_e;
        cnt_e    = EW'(r_count);

        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = count_m1;
        end
        n_cnt_e = EW'(n_count);

        rd_addr = (i_cmd.rsel == RS_TOP) ? count_m1[AW-1:0] : count_m2[AW-1:0];

        case (i_cmd.wsel)
            WS_TOP: begin
                wr_addr = count_m1[AW-1:0];
                wr_data = r_rdata;
            end
            WS_SECOND: begin
                wr_addr = count_m2[AW-1:0];
                wr_data = r_hold;
            end
            default: begin
                wr_addr = r_count[AW-1:0];
                wr_data = i_push_value;
            end
        endcase

        o_stat.full  = cnt_e >= eff_cap;
        o_stat.empty = r_count == '0;
        o_stat.two   = r_count >= CW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.hold_load) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.res_load) begin
            r_status      <= i_cmd.res_status;
            r_popped      <= i_cmd.res_popped ? r_rdata : '0;
            r_entry_count <= n_cnt_e[COUNT_OUT_W-1:0];
            r_is_full     <= n_cnt_e >= eff_cap;
            r_is_empty    <= n_count == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_entry_count  = r_entry_count;
    assign o_is_full      = r_is_full;
    assign o_is_empty     = r_is_empty;

endmodule

`default_nettype wire

### sv/bounded_stack_with_swap.sv
// Push, refused push, refused pop, short swap and unused code: result loaded into the output registers on transfer.
// Pop: the top entry is read into the read register on transfer, then loaded into the output registers from S_POP.
// Swap of two entries: two reads then two writes in turn through S_SW1, S_SW2 and S_SW3, result loaded on the last.
// A new transfer is taken only back in S_IDLE, once the last result leaves or has left.
// Synchronous active-low reset clears the count, sets the capacity to 16 and drops o_out_valid;
// the entry memory is not cleared.
`default_nettype none

module bounded_stack_with_swap #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bsws_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [bsws_pkg::OP_W-1:0]          i_op,
    input  wire logic signed [bsws_pkg::WORD_W-1:0] i_push_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [bsws_pkg::STATUS_W-1:0]           o_status,
    output logic signed [bsws_pkg::WORD_W-1:0]      o_popped_value,
    output logic [bsws_pkg::COUNT_OUT_W-1:0]        o_entry_count,
    output logic                                    o_is_full,
    output logic                                    o_is_empty
);
    import bsws_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     res_empty;
    logic     res_full;

    bsws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bsws_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push_value   (i_push_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_is_full      (o_is_full),
        .o_is_empty     (o_is_empty)
    );

    assign res_empty = o_out_valid && (o_status == ST_EMPTY);
    assign res_full  = o_out_valid && (o_status == ST_FULL);

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_ready_frees_output, o_in_ready, !o_out_valid || i_out_ready, "input ready")
    `ASSERT_IMPLY(a_empty_status, res_empty, o_is_empty && o_popped_value == '0, "empty result")
    `ASSERT_IMPLY(a_full_status, res_full, o_is_full, "full result")

endmodule

`default_nettype wire

### tb/bounded_stack_with_swap_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_swap_tb;

    import bsws_pkg::*;

    localparam int HOLD_DEPTH  = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 250000;
    localparam int SETTLE      = 12;

    typedef struct {
        t_status                   status;
        logic signed [WORD_W-1:0]  popped;
        logic [COUNT_OUT_W-1:0]    count;
        logic                      full;
        logic                      empty;
    } t_stack_result;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]                  i_cfg_wdata  = '0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_ready;
    logic [OP_W-1:0]                   i_op         = OP_NOP;
    logic signed [WORD_W-1:0]          i_push_value = '0;
    logic                              o_out_valid;
    logic                              i_out_ready  = 1'b0;
    logic [STATUS_W-1:0]               o_status;
    logic signed [WORD_W-1:0]          o_popped_value;
    logic [COUNT_OUT_W-1:0]            o_entry_count;
    logic                              o_is_full;
    logic                              o_is_empty;

    logic signed [WORD_W-1:0] stack_words [HOLD_DEPTH];
    int                       held_count    = 0;
    int                       capacity_reg  = 16;
    t_stack_result            pending_results [$];
    int                       mismatch_count = 0;
    int                       cycle_count    = 0;
    int                       stall_left     = 0;
    bit                       idling_on      = 1'b1;

    bounded_stack_with_swap #(
        .DEPTH (HOLD_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_is_full      (o_is_full),
        .o_is_empty     (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return OP_NOP;
        end else if (r < 16) begin
            return OP_SWAP;
        end else if ($urandom_range(0, 99) < push_pct) begin
            return OP_PUSH;
        end
        return OP_POP;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Applies one operation to the local copy of the stack and queues the result it should give.
    task automatic apply_stack_op(input t_op op, input logic signed [WORD_W-1:0] word);
        t_stack_result            res;
        int                       cap;
        logic signed [WORD_W-1:0] t;
        cap        = (capacity_reg > HOLD_DEPTH) ? HOLD_DEPTH : capacity_reg;
        res.status = ST_OK;
        res.popped = '0;
        case (op)
            OP_PUSH: begin
                if (held_count >= cap || held_count >= HOLD_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_words[held_count] = word;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_count--;
                    res.popped = stack_words[held_count];
                end
            end
            OP_SWAP: begin
                if (held_count >= 2) begin
                    t                           = stack_words[held_count - 1];
                    stack_words[held_count - 1] = stack_words[held_count - 2];
                    stack_words[held_count - 2] = t;
                end
            end
            default: ;
        endcase
        res.count = held_count[COUNT_OUT_W-1:0];
        res.full  = (held_count >= cap);
        res.empty = (held_count == 0);
        pending_results.push_back(res);
    endtask

    task automatic send_item(input t_op op, input logic signed [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_in_ready);
        apply_stack_op(op, word);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        capacity_reg = cap;
    endtask

    always @(negedge i_clk) begin : out_stall
        int g;
        if (!idling_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            g = pick_gap();
            i_out_ready <= (g == 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing expected, status %0d",
                                          o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_popped_value !== want.popped)
                    report_mismatch($sformatf("popped value %0d, expected %0d",
                                              o_popped_value, want.popped));
                if (o_entry_count !== want.count)
                    report_mismatch($sformatf("entry count %0d, expected %0d",
                                              o_entry_count, want.count));
                if (o_is_full !== want.full)
                    report_mismatch($sformatf("full flag %b, expected %b", o_is_full, want.full));
                if (o_is_empty !== want.empty)
                    report_mismatch($sformatf("empty flag %b, expected %b",
                                              o_is_empty, want.empty));
            end
        end
    end

    task automatic test_empty_and_basic_ops();
        send_item(OP_POP, 32'sd7);
        send_item(OP_SWAP, '0);
        send_item(OP_NOP, -32'sd1);
        send_item(OP_PUSH, 32'sh8000_0000);
        send_item(OP_SWAP, '0);
        send_item(OP_PUSH, 32'sh7fff_ffff);
        send_item(OP_PUSH, 32'sh5555_5555);
        send_item(OP_SWAP, '0);
        send_item(OP_PUSH, 32'shaaaa_aaaa);
        send_item(OP_NOP, '0);
        repeat (5) send_item(OP_POP, '0);
    endtask

    task automatic test_small_capacities();
        set_capacity(5'd1);
        send_item(OP_PUSH, -32'sd1);
        send_item(OP_PUSH, 32'sd1);
        send_item(OP_SWAP, '0);
        send_item(OP_POP, '0);
        set_capacity(5'd0);
        send_item(OP_PUSH, 32'sd3);
        send_item(OP_POP, '0);
    endtask

    task automatic test_capacity_below_count();
        set_capacity(5'd16);
        repeat (5) send_item(OP_PUSH, pick_word());
        set_capacity(5'd2);
        send_item(OP_PUSH, pick_word());
        send_item(OP_SWAP, '0);
        repeat (6) send_item(OP_POP, '0);
    endtask

    task automatic test_saturated_capacity();
        set_capacity(5'd31);
        repeat (17) send_item(OP_PUSH, pick_word());
        send_item(OP_SWAP, '0);
        repeat (17) send_item(OP_POP, '0);
    endtask

    task automatic test_random_phase(input logic [CFG_W-1:0] cap, input int items,
                                     input bit pause_midway);
        set_capacity(cap);
        for (int n = 0; n < items; n++) begin
            if (pause_midway && n == items / 2) begin
                wait_results_drained();
            end
            send_item(pick_op((n < items / 2) ? 70 : 35), pick_word());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_basic_ops();
        test_small_capacities();
        test_capacity_below_count();
        test_saturated_capacity();
        test_random_phase(5'd16, 120, 1'b1);
        test_random_phase(5'd31, 100, 1'b0);
        test_random_phase(5'($urandom_range(1, 15)), 100, 1'b0);
        idling_on = 1'b0;
        test_random_phase(5'd20, 100, 1'b0);
        idling_on = 1'b1;
        test_random_phase(5'd0, 40, 1'b0);
        test_random_phase(5'd1, 60, 1'b0);
        test_random_phase(5'($urandom_range(0, 31)), 100, 1'b1);
        test_random_phase(5'd3, 80, 1'b0);

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### bounded_stack_with_swap.f
+incdir+sv
sv/bsws_pkg.sv
sv/bsws_ctrl.sv
sv/bsws_dpath.sv
sv/bounded_stack_with_swap.sv
tb/bounded_stack_with_swap_tb.sv
